/* rtl/core/sse_pkg.sv */
// Shared constants, codes and types of the sorted set engine.
`timescale 1ns / 1ps

package sse_pkg;

   // Store geometry
   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 32;
   localparam int IDX_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   // Request operations
   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_ERASE    = 2'd1;
   localparam logic [1:0] OP_CONTAINS = 2'd2;
   localparam logic [1:0] OP_GET      = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] key;
      logic [5:0]  position;
   } sse_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] key_out;
      logic [6:0]  count;
   } sse_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic srch_rd;
      logic srch_cmp;
      logic shift_init;
      logic shift_rd;
      logic shift_wr;
      logic place;
      logic get_rd;
      logic rsp_load;
   } sse_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       srch_more;
      logic       found;
      logic       full;
      logic       shift_more;
      logic       get_ok;
   } sse_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_CMP,
      ST_SHIFT_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_GET_RD,
      ST_FINISH
   } sse_state_type;

endpackage

/* rtl/core/sse_datapath.sv */
// Datapath of the sorted set engine: key store, binary search and shift logic.
`timescale 1ns / 1ps

module sse_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  sse_pkg::sse_req_type req_word,
   input  sse_pkg::sse_cmd_type cmd,
   output sse_pkg::sse_stat_type stat,
   output sse_pkg::sse_rsp_type rsp_word
);
   import sse_pkg::*;

   logic [KEY_BITS-1:0] mem [CAPACITY];
   logic [KEY_BITS-1:0] rdata_ff;

   logic [1:0]          op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [5:0]          pos_ff;
   logic                full_ff;
   logic                found_ff, found_in;
   logic [CNT_BITS-1:0] lo_ff, lo_in;
   logic [CNT_BITS-1:0] hi_ff, hi_in;
   logic [CNT_BITS-1:0] j_ff, j_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   sse_rsp_type         rsp_ff, rsp_in;

   logic [CNT_BITS:0]   mid_sum;
   logic [CNT_BITS-1:0] mid;
   logic                get_ok;
   logic                is_insert;
   logic                rd_en, wr_en;
   logic [IDX_BITS-1:0] rd_addr, wr_addr;
   logic [KEY_BITS-1:0] wr_data;

   // Midpoint of the search window
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CNT_BITS:1];

   assign is_insert = (op_ff == OP_INSERT);
   assign get_ok    = (32'(pos_ff) < 32'(count_ff)) && (32'(pos_ff) < CAPACITY);

   // Report status to the controller
   always_comb begin
      stat.op         = op_ff;
      stat.srch_more  = (lo_ff < hi_ff);
      stat.found      = found_ff;
      stat.full       = full_ff;
      stat.shift_more = is_insert ? (j_ff > lo_ff) : (j_ff < count_ff);
      stat.get_ok     = get_ok;
   end

   // Select memory read and write ports
   always_comb begin
      rd_en   = cmd.srch_rd || cmd.shift_rd || cmd.get_rd;
      rd_addr = IDX_BITS'(mid);
      if (cmd.shift_rd) begin
         rd_addr = is_insert ? IDX_BITS'(j_ff - 1'b1) : IDX_BITS'(j_ff);
      end else if (cmd.get_rd) begin
         rd_addr = IDX_BITS'(pos_ff);
      end
      wr_en   = cmd.shift_wr || (cmd.place && is_insert);
      wr_addr = is_insert ? IDX_BITS'(j_ff) : IDX_BITS'(j_ff - 1'b1);
      wr_data = rdata_ff;
      if (cmd.place) begin
         wr_addr = IDX_BITS'(lo_ff);
         wr_data = key_ff;
      end
   end

   // Key store with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Next search window, shift index and count
   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      found_in = found_ff;
      j_in     = j_ff;
      count_in = count_ff;
      if (cmd.load) begin
         lo_in    = '0;
         hi_in    = count_ff;
         found_in = 1'b0;
      end else if (cmd.srch_cmp) begin
         if (rdata_ff < key_ff) begin
            lo_in = CNT_BITS'({1'b0, mid} + 1'b1);
         end else begin
            hi_in = mid;
         end
         if (rdata_ff == key_ff) begin
            found_in = 1'b1;
         end
      end
      if (cmd.shift_init) begin
         j_in = is_insert ? count_ff : CNT_BITS'({1'b0, lo_ff} + 1'b1);
      end else if (cmd.shift_wr) begin
         j_in = is_insert ? CNT_BITS'(j_ff - 1'b1) : CNT_BITS'(j_ff + 1'b1);
      end
      if (cmd.place) begin
         count_in = is_insert ? CNT_BITS'(count_ff + 1'b1) : CNT_BITS'(count_ff - 1'b1);
      end
   end

   // Build the result word
   always_comb begin
      rsp_in.count   = 7'(count_ff);
      rsp_in.key_out = '0;
      rsp_in.status  = STATUS_DONE;
      unique case (op_ff) inside
         OP_INSERT: begin
            if (found_ff) begin
               rsp_in.status = STATUS_REJECT;
            end else if (full_ff) begin
               rsp_in.status = STATUS_FULL;
            end
         end
         OP_ERASE, OP_CONTAINS: begin
            if (!found_ff) begin
               rsp_in.status = STATUS_REJECT;
            end
         end
         default: begin
            if (get_ok) begin
               rsp_in.key_out = 32'(rdata_ff);
            end else begin
               rsp_in.status = STATUS_REJECT;
            end
         end
      endcase
   end

   // Hold request fields and working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_word.op;
         key_ff  <= KEY_BITS'(req_word.key);
         pos_ff  <= req_word.position;
         full_ff <= (32'(count_ff) >= CAPACITY);
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      found_ff <= found_in;
      j_ff     <= j_in;
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Count of held keys
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_word = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("key count above capacity");

   a_count_only_on_place: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.place) |-> $stable(count_ff))
      else $error("key count changed outside a commit");

   a_shift_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_wr |-> (32'(wr_addr) <= 32'(count_ff)))
      else $error("shift write beyond held keys");

endmodule

/* rtl/core/sse_controller.sv */
// Controller state machine of the sorted set engine.
`timescale 1ns / 1ps

module sse_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sse_pkg::sse_stat_type stat,
   output sse_pkg::sse_cmd_type  cmd
);
   import sse_pkg::*;

   sse_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (stat.op == OP_GET) begin
               state_in = ST_GET_RD;
            end else if (stat.srch_more) begin
               state_in = ST_SEARCH_CMP;
            end else if (stat.op == OP_INSERT && !stat.found && !stat.full) begin
               state_in = ST_SHIFT_CHK;
            end else if (stat.op == OP_ERASE && stat.found) begin
               state_in = ST_SHIFT_CHK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SEARCH_CMP: state_in = ST_SEARCH;
         ST_SHIFT_CHK: begin
            state_in = stat.shift_more ? ST_SHIFT_RD : ST_PLACE;
         end
         ST_SHIFT_RD:  state_in = ST_SHIFT_WR;
         ST_SHIFT_WR:  state_in = ST_SHIFT_CHK;
         ST_PLACE:     state_in = ST_FINISH;
         ST_GET_RD:    state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Commands per state
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SEARCH: begin
            cmd.srch_rd    = (stat.op != OP_GET) && stat.srch_more;
            cmd.shift_init = (stat.op != OP_GET) && !stat.srch_more;
         end
         ST_SEARCH_CMP: cmd.srch_cmp = 1'b1;
         ST_SHIFT_RD:   cmd.shift_rd = 1'b1;
         ST_SHIFT_WR:   cmd.shift_wr = 1'b1;
         ST_PLACE:      cmd.place    = 1'b1;
         ST_GET_RD:     cmd.get_rd   = stat.get_ok;
         ST_FINISH:     cmd.rsp_load = rsp_free;
         default: begin
         end
      endcase
   end

   // Result valid: set on load, drop on take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside finish");

   a_accept_starts_search: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SEARCH)
      else $error("accepted word did not start a search");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

endmodule

/* rtl/core/sorted_set_engine.sv */
// Top level of the sorted set engine.
`timescale 1ns / 1ps
// Usage: keeps up to 64 distinct 32-bit keys in ascending order.
// Request channel (req_valid/req_ready/req_word) carries op, key and position;
// op selects insert, erase, contains or get by rank. Result channel
// (rsp_valid/rsp_ready/rsp_word) returns one word per request: status, key at
// the rank for get (else zero), and the key count after the request.
// Timing: one request at a time. Each binary search probe is a read state then
// a compare state, at most ceil(log2(count+1)) probes. Insert then moves each
// key at or above the slot up, and erase each key above it down, each move a
// check, a read and a write in the key store, plus a final check and a commit.
// From accept, contains and rejected requests run the search and then finish;
// a committed insert or erase runs the search, the moves and the commit first;
// get reads the rank and finishes. The result is registered, and req_ready
// returns the cycle after the result is loaded, even while that result waits
// to be taken.
// Reset clears the count and the handshake state; store contents need none.
// When the receiver stalls, the finished word holds in the output register and
// the engine waits until it is taken before it loads the next one.

module sorted_set_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sse_pkg::sse_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sse_pkg::sse_rsp_type rsp_word
);
   import sse_pkg::*;

   sse_cmd_type  cmd;
   sse_stat_type stat;

   // Sequence the request
   sse_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store, search and shift keys
   sse_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule
